// File: rtl/lru_pkg.sv
// Shared types and constants for the LRU cache lookup/insert core.
// Used by the controller, the datapath and the top level; no dependencies.
package lru_pkg;

  localparam int KEY_W      = 32;
  localparam int VALUE_W    = 32;
  localparam int CAP_W      = 5;
  localparam int EVICT_W    = 5;
  localparam int S_DATA_W   = ((KEY_W + VALUE_W + 7) / 8) * 8;
  localparam int M_DATA_W   = ((VALUE_W + EVICT_W + 7) / 8) * 8;
  localparam int M_PAD_W    = M_DATA_W - VALUE_W - EVICT_W;

  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_KEY_BITS   = 32;
  localparam int DEF_VALUE_BITS = 32;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic load;
    logic compare;
    logic update;
  } ctrl_cmd_t;

endpackage

// File: rtl/lru_ctrl.sv
// Sequencing controller for the LRU cache core: request handshakes and step commands.
// Depends on lru_pkg for the command struct.
module lru_ctrl import lru_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  output ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   accept;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) || ((state == S_UPD) && out_free);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd.load    = accept;
    cmd.compare = (state == S_CMP);
    cmd.update  = (state == S_UPD) && out_free;
    state_next  = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          state_next = accept ? S_CMP : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.update) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/lru_datapath.sv
// Datapath of the LRU cache core: entry storage, parallel key compare and recency update.
// Depends on lru_pkg; driven by the command struct from lru_ctrl.
module lru_datapath import lru_pkg::*; #(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_cmd_t          cmd,
  input  logic               cfg_write,
  input  logic [CAP_W-1:0]   cfg_capacity,
  input  cmd_t               req_cmd,
  input  logic [KEY_W-1:0]   req_key,
  input  logic [VALUE_W-1:0] req_fill,
  output logic               out_hit,
  output logic [VALUE_W-1:0] out_value,
  output logic [EVICT_W-1:0] out_evict
);

  localparam int RW   = $clog2(ENTRIES);
  localparam int CNTW = $clog2(ENTRIES + 1);
  localparam int CMPW = RW + CAP_W + 1;

  logic [KEY_BITS-1:0]   keys [ENTRIES];
  logic [VALUE_BITS-1:0] vals [ENTRIES];
  logic [ENTRIES-1:0]    valid;
  logic [RW-1:0]         rank [ENTRIES];
  logic [CAP_W-1:0]      capacity;

  cmd_t                  in_cmd;
  logic [KEY_BITS-1:0]   in_key;
  logic [VALUE_BITS-1:0] in_fill;

  logic                  hit_r;
  logic [RW-1:0]         hit_idx;
  logic [ENTRIES-1:0]    drop_r;

  logic                  hit_c;
  logic [RW-1:0]         hit_idx_c;
  logic [ENTRIES-1:0]    drop_c;
  logic [CMPW-1:0]       cap_eff;
  logic [RW-1:0]         keep;

  logic [ENTRIES-1:0]    valid_next;
  logic [RW-1:0]         rank_next [ENTRIES];
  logic [ENTRIES-1:0]    kept;
  logic [RW-1:0]         slot;
  logic                  slot_found;
  logic [CNTW-1:0]       dropped;
  logic [RW-1:0]         hit_rank;

  always_comb begin
    cap_eff = CMPW'(capacity);
    if (cap_eff == '0) begin
      cap_eff = CMPW'(1);
    end else if (cap_eff > CMPW'(ENTRIES)) begin
      cap_eff = CMPW'(ENTRIES);
    end
    keep      = RW'(cap_eff - CMPW'(1));
    hit_c     = 1'b0;
    hit_idx_c = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      drop_c[i] = valid[i] && (rank[i] >= keep);
      if (valid[i] && (keys[i] == in_key) && !hit_c) begin
        hit_c     = 1'b1;
        hit_idx_c = RW'(i);
      end
    end
  end

  always_comb begin
    hit_rank   = rank[hit_idx];
    kept       = valid & ~drop_r;
    valid_next = valid;
    slot       = '0;
    slot_found = 1'b0;
    dropped    = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_next[i] = rank[i];
      dropped      = dropped + CNTW'(drop_r[i]);
      if (!kept[i] && !slot_found) begin
        slot       = RW'(i);
        slot_found = 1'b1;
      end
    end
    if (in_cmd == CMD_CLEAR) begin
      valid_next = '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_next[i] = '0;
      end
    end else if (hit_r) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid[i] && (rank[i] < hit_rank)) begin
          rank_next[i] = rank[i] + 1'b1;
        end
      end
      rank_next[hit_idx] = '0;
    end else begin
      valid_next = kept;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_next[i] = kept[i] ? rank[i] + 1'b1 : '0;
      end
      valid_next[slot] = 1'b1;
      rank_next[slot]  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      capacity <= CAPACITY_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        capacity <= cfg_capacity;
      end
      if (cmd.update) begin
        valid <= valid_next;
        for (int i = 0; i < ENTRIES; i++) begin
          rank[i] <= rank_next[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && (in_cmd == CMD_LOOKUP) && !hit_r) begin
      keys[slot] <= in_key;
      vals[slot] <= in_fill;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_cmd  <= req_cmd;
      in_key  <= KEY_BITS'(req_key);
      in_fill <= VALUE_BITS'(req_fill);
    end
    if (cmd.compare) begin
      hit_r   <= hit_c;
      hit_idx <= hit_idx_c;
      drop_r  <= drop_c;
    end
    if (cmd.update) begin
      if (in_cmd == CMD_CLEAR) begin
        out_hit   <= 1'b0;
        out_value <= '0;
        out_evict <= '0;
      end else if (hit_r) begin
        out_hit   <= 1'b1;
        out_value <= VALUE_W'(vals[hit_idx]);
        out_evict <= '0;
      end else begin
        out_hit   <= 1'b0;
        out_value <= VALUE_W'(in_fill);
        out_evict <= EVICT_W'(dropped);
      end
    end
  end

endmodule

// File: rtl/lru_cache_lookup_insert_core.sv
// Top level of the fully associative LRU cache lookup/insert core.
// Instantiates lru_ctrl and lru_datapath; depends on lru_pkg.
//
// Each request on the slave stream carries a key and a fill value (tdata) and
// a command (tuser): lookup/insert or clear. Every request yields exactly one
// result on the master stream: the hit flag (tuser), and the returned value
// with the number of evicted entries (tdata).
// A request is registered on acceptance, compared against all entries in the
// next cycle and applied in the update step, which loads the output register.
// A new request is taken in the same cycle as the update of the previous one,
// so the core takes no request while one is in the compare step; this is set
// by the compare and update steps that share the entry storage.
// The capacity register is written through the cfg channel, which is always
// ready, and must only be written while the core is idle.
// Reset empties the cache and sets the capacity to 16. While the receiver
// stalls, the result is held and at most one further request is taken; it then
// waits in the update step until the output register is free.
module lru_cache_lookup_insert_core import lru_pkg::*; #(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CAP_W-1:0]    cfg_data,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // key, fill_value
  input  logic [0:0]          s_tuser,   // cmd
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // value, evicted_count, zero padding
  output logic [0:0]          m_tuser    // hit
);

  ctrl_cmd_t          cmd;
  logic               out_hit;
  logic [VALUE_W-1:0] out_value;
  logic [EVICT_W-1:0] out_evict;

  assign cfg_ready = 1'b1;

  lru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  lru_datapath #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_capacity (cfg_data),
    .req_cmd      (cmd_t'(s_tuser[0])),
    .req_key      (s_tdata[KEY_W-1:0]),
    .req_fill     (s_tdata[KEY_W+VALUE_W-1:KEY_W]),
    .out_hit      (out_hit),
    .out_value    (out_value),
    .out_evict    (out_evict)
  );

  assign m_tdata = {{M_PAD_W{1'b0}}, out_evict, out_value};
  assign m_tuser = out_hit;

endmodule

// File: dv/tb_lru_cache_lookup_insert_core.sv
// Self-checking testbench for lru_cache_lookup_insert_core: directed and random requests
// are checked against a behavioral LRU model held in a small scoreboard class.
// Depends on lru_pkg and the core RTL only.
`timescale 1ns / 100ps

typedef struct {
  logic                          hit;
  logic [lru_pkg::VALUE_W-1:0]   data;
  logic [lru_pkg::EVICT_W-1:0]   evicted;
} lru_outcome_t;

class lru_scoreboard;
  localparam int SLOTS = lru_pkg::DEF_ENTRIES;

  logic [lru_pkg::KEY_W-1:0]   slot_key[SLOTS];
  logic [lru_pkg::VALUE_W-1:0] slot_value[SLOTS];
  bit                          slot_valid[SLOTS];
  int                          slot_age[SLOTS];
  int                          occupancy;
  logic [lru_pkg::CAP_W-1:0]   capacity;
  lru_outcome_t                outcomes_due[$];
  int                          errors;

  function new();
    foreach (slot_valid[i]) begin
      slot_valid[i] = 1'b0;
      slot_age[i]   = 0;
    end
    occupancy = 0;
    capacity  = lru_pkg::CAPACITY_RESET;
    errors    = 0;
  endfunction

  function void set_capacity(logic [lru_pkg::CAP_W-1:0] cap);
    capacity = cap;
  endfunction

  function int pending();
    return outcomes_due.size();
  endfunction

  // Updates the cache image for one accepted request and queues its outcome.
  function void note_request(lru_pkg::cmd_t cmd, logic [lru_pkg::KEY_W-1:0] key,
                             logic [lru_pkg::VALUE_W-1:0] fill);
    lru_outcome_t outcome;
    int match;
    int keep;
    int dropped;
    int slot;
    int age;
    match = -1;
    slot  = -1;
    dropped = 0;
    if (cmd == lru_pkg::CMD_CLEAR) begin
      foreach (slot_valid[i]) begin
        slot_valid[i] = 1'b0;
        slot_age[i]   = 0;
      end
      occupancy = 0;
      outcome.hit = 1'b0;
      outcome.data = '0;
      outcome.evicted = '0;
      outcomes_due.push_back(outcome);
      return;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (match < 0 && slot_valid[i] && slot_key[i] == key) begin
        match = i;
      end
    end
    if (match >= 0) begin
      age = slot_age[match];
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_valid[i] && slot_age[i] < age) begin
          slot_age[i]++;
        end
      end
      slot_age[match] = 0;
      outcome.hit = 1'b1;
      outcome.data = slot_value[match];
      outcome.evicted = '0;
    end else begin
      keep = (capacity == 0) ? 1 : ((capacity > SLOTS) ? SLOTS : int'(capacity));
      keep = keep - 1;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_valid[i] && slot_age[i] >= keep) begin
          slot_valid[i] = 1'b0;
          slot_age[i]   = 0;
          dropped++;
        end
      end
      occupancy = (occupancy >= dropped) ? occupancy - dropped : 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_valid[i]) begin
          slot_age[i]++;
        end else if (slot < 0) begin
          slot = i;
        end
      end
      if (slot >= 0) begin
        slot_key[slot]   = key;
        slot_value[slot] = fill;
        slot_valid[slot] = 1'b1;
        slot_age[slot]   = 0;
        occupancy++;
      end
      outcome.hit = 1'b0;
      outcome.data = fill;
      outcome.evicted = lru_pkg::EVICT_W'(dropped);
    end
    outcomes_due.push_back(outcome);
  endfunction

  function void check_result(logic hit, logic [lru_pkg::VALUE_W-1:0] data,
                             logic [lru_pkg::EVICT_W-1:0] evicted);
    lru_outcome_t want;
    if (outcomes_due.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("[%0t] unexpected result: hit=%0b value=%h evicted=%0d",
                 $realtime, hit, data, evicted);
      end
      return;
    end
    want = outcomes_due.pop_front();
    if (hit !== want.hit || data !== want.data || evicted !== want.evicted) begin
      errors++;
      if (errors <= 10) begin
        $display({"[%0t] mismatch: expected hit=%0b value=%h evicted=%0d,",
                  " got hit=%0b value=%h evicted=%0d"},
                 $realtime, want.hit, want.data, want.evicted, hit, data, evicted);
      end
    end
  endfunction
endclass

module tb_lru_cache_lookup_insert_core;
  import lru_pkg::*;

  localparam int STUCK_LIMIT = 2000;
  localparam int PHASE_ITEMS = 90;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CAP_W-1:0]    cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;    // key, fill_value
  logic [0:0]          s_tuser = '0;    // cmd
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;         // value, evicted_count, zero padding
  logic [0:0]          m_tuser;         // hit

  lru_scoreboard sb = new();
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int rx_hold = 0;
  int stuck_cycles = 0;
  logic [KEY_W-1:0] key_pool[$];

  lru_cache_lookup_insert_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin : rx_ready_gen
    int unsigned stall_draw;
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold <= 0;
    end else if (m_tready) begin
      if (m_tvalid) begin
        stall_draw = rx_idle_en ? $urandom_range(0, 5) : 0;
        if (stall_draw != 0) begin
          m_tready <= 1'b0;
          rx_hold <= stall_draw;
        end
      end
    end else if (rx_hold <= 1) begin
      m_tready <= 1'b1;
      rx_hold <= 0;
    end else begin
      rx_hold <= rx_hold - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tuser[0], m_tdata[VALUE_W-1:0], m_tdata[VALUE_W +: EVICT_W]);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb_lru_cache_lookup_insert_core failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_request(cmd_t cmd, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] fill);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= S_DATA_W'({fill, key});
    do @(posedge clk); while (!s_tready);
    sb.note_request(cmd, key, fill);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    wait_drained();
    repeat (6) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_capacity(cap);
  endtask

  task automatic run_directed();
    logic [KEY_W-1:0] ka, kb, kc, kd, ke;
    ka = $urandom;
    kb = ka ^ 32'h0000_0001;
    kc = ~ka;
    kd = $urandom;
    ke = kd + 32'h8000_0000;
    write_capacity(5'd3);
    send_request(CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(CMD_LOOKUP, 32'h0000_0000, 32'h5A5A_5A5A);
    send_request(CMD_LOOKUP, ka, $urandom);
    send_request(CMD_LOOKUP, kb, $urandom);
    send_request(CMD_LOOKUP, ka, $urandom);
    send_request(CMD_CLEAR, $urandom, $urandom);
    send_request(CMD_LOOKUP, 32'h0000_0000, $urandom);
    write_capacity(5'd0);
    send_request(CMD_LOOKUP, kc, $urandom);
    send_request(CMD_LOOKUP, kc, $urandom);
    send_request(CMD_LOOKUP, kd, $urandom);
    write_capacity(5'd4);
    send_request(CMD_LOOKUP, 32'h0000_0000, $urandom);
    send_request(CMD_LOOKUP, ka, $urandom);
    send_request(CMD_LOOKUP, kb, $urandom);
    send_request(CMD_LOOKUP, ke, $urandom);
    write_capacity(5'd1);
    send_request(CMD_LOOKUP, kb, $urandom);
    send_request(CMD_LOOKUP, kc, $urandom);
  endtask

  task automatic run_phase(int phase, logic [CAP_W-1:0] cap);
    int unsigned pool_size;
    int unsigned roll;
    logic [KEY_W-1:0] key;
    write_capacity(cap);
    tx_idle_en = (phase % 3) != 1;
    rx_idle_en = (phase % 4) != 2;
    key_pool.delete();
    pool_size = $urandom_range(4, 24);
    repeat (pool_size) key_pool.push_back($urandom);
    if (phase == 0) begin
      key_pool.push_back(32'h0000_0000);
      key_pool.push_back(32'hFFFF_FFFF);
    end
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (phase == 2 && n == PHASE_ITEMS / 2) begin
        wait_drained();
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        send_request(CMD_CLEAR, $urandom, $urandom);
      end else begin
        key = (roll < 13) ? $urandom : key_pool[$urandom_range(0, key_pool.size() - 1)];
        send_request(CMD_LOOKUP, key, $urandom);
      end
    end
  endtask

  initial begin
    logic [CAP_W-1:0] caps[9];
    caps = '{5'd31, 5'd1, 5'd16, 5'd0, 5'd5, 5'd17, 5'd2, 5'd8, 5'd0};
    caps[8] = CAP_W'($urandom_range(0, 31));
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    foreach (caps[p]) begin
      run_phase(p, caps[p]);
    end
    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_lru_cache_lookup_insert_core passed");
    end else begin
      $display("tb_lru_cache_lookup_insert_core failed");
    end
    $finish;
  end

endmodule
